/* hw/rtl/rrps_pkg.sv */
// Shared types and constants of the round-robin process scheduler.
// Holds operation and result codes, field widths and the queue entry type.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package rrps_pkg;

  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int ADDR_W  = 16;
  localparam int CODE_W  = 2;
  localparam int QCNT_W  = 5;
  localparam int TICK_W  = 16;

  localparam logic [TICK_W-1:0] QUANTUM_RESET = 16'd10;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_TERMINATE = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD       = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE    = 2'd3;

  // Result codes of an output word.
  localparam logic [CODE_W-1:0] RES_OK        = 2'd0;
  localparam logic [CODE_W-1:0] RES_NONE      = 2'd1;
  localparam logic [CODE_W-1:0] RES_FULL      = 2'd2;
  localparam logic [CODE_W-1:0] RES_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Per-cell control: load the new entry, or shift, taking either the
  // right-hand neighbour or the recirculated head.
  typedef struct packed {
    logic take_in;
    logic shift;
    logic take_head;
  } cell_ctl_t;

endpackage

/* hw/rtl/rrps_in_if.sv */
// Input channel of the round-robin process scheduler: valid, ready and one
// request word. Depends on rrps_pkg for the field widths.
`timescale 1ns / 1ps

interface rrps_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrps_pkg::OP_W-1:0]   operation;
  logic [rrps_pkg::ID_W-1:0]   pid;
  logic [rrps_pkg::ADDR_W-1:0] base;

  modport source (output valid, output operation, output pid, output base, input ready);
  modport sink (input valid, input operation, input pid, input base, output ready);
endinterface

/* hw/rtl/rrps_out_if.sv */
// Result channel of the round-robin process scheduler: valid, ready and one
// result word. Depends on rrps_pkg for the field widths.
`timescale 1ns / 1ps

interface rrps_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrps_pkg::CODE_W-1:0] result_code;
  logic                        switched;
  logic [rrps_pkg::ID_W-1:0]   current_pid;
  logic [rrps_pkg::ADDR_W-1:0] current_base;
  logic [rrps_pkg::QCNT_W-1:0] queue_count;

  modport source (output valid, output result_code, output switched, output current_pid,
                  output current_base, output queue_count, input ready);
  modport sink (input valid, input result_code, input switched, input current_pid,
                input current_base, input queue_count, output ready);
endinterface

/* hw/rtl/rrps_cfg_if.sv */
// Configuration write channel of the round-robin process scheduler, carrying
// the quantum. Depends on rrps_pkg for the width.
`timescale 1ns / 1ps

interface rrps_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rrps_pkg::TICK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rrps_cell.sv */
// One slot of the scheduler's shifting ready queue.
// Depends on rrps_pkg for the entry and control types.
`timescale 1ns / 1ps

module rrps_cell (
  input  logic               clk,
  input  rrps_pkg::cell_ctl_t ctl,
  input  rrps_pkg::entry_t   new_entry,
  input  rrps_pkg::entry_t   right_entry,
  input  rrps_pkg::entry_t   head_entry,
  output rrps_pkg::entry_t   entry
);

  rrps_pkg::entry_t entry_r;
  rrps_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.take_in) begin
      entry_nxt = new_entry;
    end else if (ctl.shift) begin
      entry_nxt = ctl.take_head ? head_entry : right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* hw/rtl/round_robin_process_scheduler_unit.sv */
// Round-robin process scheduler. The ready queue is a row of DEPTH cells with
// the running process always in the first cell; each cell either keeps its
// entry, loads a new one, or takes its right-hand neighbour's entry or the
// recirculated head, so a rotation or a termination is one shift of the whole
// row. A tick, a terminate or an add is accepted in the idle state, goes to the
// done state, and from there reaches the result register once that register
// is free; the next word is accepted after that. A remove circulates the whole
// queue once past the comparator on the first cell, one entry a cycle, dropping
// the first match, in the walk state, and then goes on to the done state in the
// same way. The result register lets a new word in while the previous result
// waits; a second result then holds the input until the first one has been
// taken.
`timescale 1ns / 1ps

module round_robin_process_scheduler_unit #(
  parameter int DEPTH = 16
) (
  input logic           clk,
  input logic           rst_n,
  rrps_in_if.sink       in_ch,
  rrps_out_if.source    out_ch,
  rrps_cfg_if.sink      cfg_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [CNT_W-1:0]                  step_r, step_nxt;
  logic [rrps_pkg::TICK_W-1:0]       slice_r, slice_nxt;
  logic [rrps_pkg::TICK_W-1:0]       quantum_r;
  logic [rrps_pkg::ID_W-1:0]         pid_r, pid_nxt;
  logic                              found_r, found_nxt;
  logic                              first_r, first_nxt;
  logic [rrps_pkg::CODE_W-1:0]       code_r, code_nxt;
  logic                              sw_r, sw_nxt;

  logic                              out_valid_r;
  logic [rrps_pkg::CODE_W-1:0]       out_code_r;
  logic                              out_sw_r;
  logic [rrps_pkg::ID_W-1:0]         out_pid_r;
  logic [rrps_pkg::ADDR_W-1:0]       out_base_r;
  logic [rrps_pkg::QCNT_W-1:0]       out_count_r;

  logic                              in_fire;
  logic                              out_load;
  logic                              do_shift;
  logic                              do_recirc;
  logic                              do_load;
  logic [CNT_W-1:0]                  tail_pos;
  logic                              head_match;

  rrps_pkg::entry_t                  new_entry;
  rrps_pkg::entry_t                  cell_q [DEPTH];

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign new_entry = '{id: in_ch.pid, addr: in_ch.base};
  assign head_match = !found_r && (cell_q[0].id == pid_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    slice_nxt = slice_r;
    pid_nxt   = pid_r;
    found_nxt = found_r;
    first_nxt = first_r;
    code_nxt  = code_r;
    sw_nxt    = sw_r;
    do_shift  = 1'b0;
    do_recirc = 1'b0;
    do_load   = 1'b0;
    tail_pos  = count_r - ONE_CNT;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DONE;
          code_nxt  = rrps_pkg::RES_OK;
          sw_nxt    = 1'b0;
          unique case (in_ch.operation)
            rrps_pkg::OP_TICK: begin
              if (count_r == '0) begin
                code_nxt = rrps_pkg::RES_NONE;
              end else if (slice_r == quantum_r) begin
                slice_nxt = '0;
                if (count_r > ONE_CNT) begin
                  do_shift  = 1'b1;
                  do_recirc = 1'b1;
                  sw_nxt    = 1'b1;
                end
              end else begin
                slice_nxt = slice_r + 1'b1;
              end
            end
            rrps_pkg::OP_TERMINATE: begin
              if (count_r == '0) begin
                code_nxt = rrps_pkg::RES_NONE;
              end else begin
                do_shift  = 1'b1;
                count_nxt = count_r - ONE_CNT;
                slice_nxt = '0;
                if (count_r == ONE_CNT) begin
                  code_nxt = rrps_pkg::RES_NONE;
                end else begin
                  sw_nxt = 1'b1;
                end
              end
            end
            rrps_pkg::OP_ADD: begin
              if (count_r >= FULL_CNT) begin
                code_nxt = rrps_pkg::RES_FULL;
              end else begin
                do_load   = 1'b1;
                count_nxt = count_r + ONE_CNT;
                if (count_r == '0) begin
                  sw_nxt    = 1'b1;
                  slice_nxt = '0;
                end
              end
            end
            rrps_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                code_nxt = rrps_pkg::RES_NONE;
              end else begin
                state_nxt = S_WALK;
                step_nxt  = count_r;
                pid_nxt   = in_ch.pid;
                found_nxt = 1'b0;
                first_nxt = 1'b1;
              end
            end
            default: begin
              code_nxt = rrps_pkg::RES_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        // Every entry passes the first cell once; the first match is
        // dropped, all others go back in at the tail in their old order.
        do_shift  = 1'b1;
        do_recirc = !head_match;
        first_nxt = 1'b0;
        step_nxt  = step_r - ONE_CNT;
        if (head_match) begin
          found_nxt = 1'b1;
          count_nxt = count_r - ONE_CNT;
          if (first_r) begin
            slice_nxt = '0;
          end
        end
        if (step_r == ONE_CNT) begin
          state_nxt = S_DONE;
          if (!(found_r || head_match)) begin
            code_nxt = rrps_pkg::RES_NOT_FOUND;
            sw_nxt   = 1'b0;
          end else if (count_nxt == '0) begin
            code_nxt = rrps_pkg::RES_NONE;
            sw_nxt   = 1'b0;
          end else begin
            code_nxt = rrps_pkg::RES_OK;
            sw_nxt   = first_r && head_match;
          end
        end else if (first_r && head_match) begin
          // Remember that the head itself went; reported at the end.
          sw_nxt = 1'b1;
        end else if (first_r) begin
          sw_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The last-step switched flag must include a head match seen earlier.
  logic sw_fix;
  assign sw_fix = (state_r == S_WALK) && (step_r == ONE_CNT) && (code_nxt == rrps_pkg::RES_OK)
                  && !first_r && sw_r;

  generate
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      localparam logic [CNT_W-1:0] POS = CNT_W'(k);
      rrps_pkg::cell_ctl_t ctl;
      rrps_pkg::entry_t    right_entry;

      assign ctl.take_in   = do_load && (count_r == POS);
      assign ctl.shift     = do_shift;
      assign ctl.take_head = do_recirc && (tail_pos == POS);
      if (k == DEPTH - 1) begin : g_last
        assign right_entry = cell_q[k];
      end else begin : g_mid
        assign right_entry = cell_q[k+1];
      end

      rrps_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .right_entry (right_entry),
        .head_entry  (cell_q[0]),
        .entry       (cell_q[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      slice_r     <= '0;
      quantum_r   <= rrps_pkg::QUANTUM_RESET;
      found_r     <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      slice_r <= slice_nxt;
      found_r <= found_nxt;
      first_r <= first_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        quantum_r <= cfg_ch.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pid_r  <= pid_nxt;
    code_r <= code_nxt;
    sw_r   <= sw_nxt || sw_fix;
    if (out_load) begin
      out_code_r  <= code_r;
      out_sw_r    <= sw_r;
      out_count_r <= rrps_pkg::QCNT_W'(count_r);
      if (count_r != '0) begin
        out_pid_r  <= cell_q[0].id;
        out_base_r <= cell_q[0].addr;
      end else begin
        out_pid_r  <= '0;
        out_base_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_code  = out_code_r;
  assign out_ch.switched     = out_sw_r;
  assign out_ch.current_pid  = out_pid_r;
  assign out_ch.current_base = out_base_r;
  assign out_ch.queue_count  = out_count_r;

endmodule

/* sim/tb_round_robin_process_scheduler_unit.sv */
// Self-checking testbench for the round-robin process scheduler: a directed table,
// then random phases under several quanta, each result checked against a predictor.
// Depends on rrps_pkg, the three channel interfaces and the scheduler top level.
`timescale 1ns / 1ps

module tb_round_robin_process_scheduler_unit;

  localparam int QDEPTH = 16;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 165;

  typedef struct packed {
    logic [rrps_pkg::CODE_W-1:0] code;
    logic                        sw;
    logic [rrps_pkg::ID_W-1:0]   pid;
    logic [rrps_pkg::ADDR_W-1:0] base;
    logic [rrps_pkg::QCNT_W-1:0] count;
  } sched_result_t;

  typedef enum logic {ROW_WORD, ROW_QUANTUM} row_kind_t;

  // A row either sends reps words (pid and base stepping by one) or writes the quantum.
  typedef struct packed {
    row_kind_t                   kind;
    logic [rrps_pkg::OP_W-1:0]   op;
    logic [rrps_pkg::ID_W-1:0]   pid;
    logic [rrps_pkg::ADDR_W-1:0] base;
    logic [rrps_pkg::TICK_W-1:0] quantum;
    logic [31:0]                 reps;
    logic                        typed;
    sched_result_t               want;
  } step_row_t;

  localparam sched_result_t EMPTY_NONE = '{rrps_pkg::RES_NONE, 1'b0, 16'h0000, 16'h0000, 5'd0};

  logic clk = 1'b0;
  logic rst_n;

  rrps_in_if  in_ch();
  rrps_out_if out_ch();
  rrps_cfg_if cfg_ch();

  round_robin_process_scheduler_unit #(.DEPTH(QDEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // Predicted scheduler state.
  logic [rrps_pkg::ID_W-1:0]   q_id [QDEPTH];
  logic [rrps_pkg::ADDR_W-1:0] q_addr [QDEPTH];
  int unsigned                 q_head;
  int unsigned                 q_count;
  logic [rrps_pkg::TICK_W-1:0] q_ticks;
  logic [rrps_pkg::TICK_W-1:0] q_quantum;

  sched_result_t pending_results [$];
  sched_result_t seen_word;
  sched_result_t wanted_word;
  int mismatch_count = 0;
  int results_seen = 0;

  int burst_left = 0;
  int gap_cycles;
  int holdoff_asked = 0;
  int holdoff_given = 0;
  int holdoff_left = 0;
  int pattern_step = 0;
  logic [7:0] stall_pattern = 8'hFF;

  function automatic int unsigned slot_at(input int unsigned pos);
    return (q_head + pos) % QDEPTH;
  endfunction

  function automatic void retire_head();
    q_head = slot_at(1);
    q_count--;
    q_ticks = '0;
  endfunction

  function automatic sched_result_t schedule_step(input logic [rrps_pkg::OP_W-1:0] op,
                                                  input logic [rrps_pkg::ID_W-1:0] pid,
                                                  input logic [rrps_pkg::ADDR_W-1:0] base);
    sched_result_t r;
    int unsigned tail;
    int unsigned found;
    r = '0;
    r.code = rrps_pkg::RES_OK;
    case (op)
      rrps_pkg::OP_TICK: begin
        if (q_count == 0) begin
          r.code = rrps_pkg::RES_NONE;
        end else if (q_ticks == q_quantum) begin
          q_ticks = '0;
          if (q_count > 1) begin
            // When the queue is full the tail slot is the head slot itself.
            tail = slot_at(q_count % QDEPTH);
            q_id[tail] = q_id[q_head];
            q_addr[tail] = q_addr[q_head];
            q_head = slot_at(1);
            r.sw = 1'b1;
          end
        end else begin
          q_ticks = q_ticks + 1'b1;
        end
      end
      rrps_pkg::OP_TERMINATE: begin
        if (q_count == 0) begin
          r.code = rrps_pkg::RES_NONE;
        end else begin
          retire_head();
          if (q_count == 0) r.code = rrps_pkg::RES_NONE;
          else r.sw = 1'b1;
        end
      end
      rrps_pkg::OP_ADD: begin
        if (q_count >= QDEPTH) begin
          r.code = rrps_pkg::RES_FULL;
        end else begin
          tail = slot_at(q_count);
          q_id[tail] = pid;
          q_addr[tail] = base;
          q_count++;
          if (q_count == 1) begin
            r.sw = 1'b1;
            q_ticks = '0;
          end
        end
      end
      default: begin
        if (q_count == 0) begin
          r.code = rrps_pkg::RES_NONE;
        end else begin
          found = q_count;
          for (int unsigned k = 0; k < q_count; k++) begin
            if (found == q_count && q_id[slot_at(k)] == pid) found = k;
          end
          if (found == q_count) begin
            r.code = rrps_pkg::RES_NOT_FOUND;
          end else if (found == 0) begin
            retire_head();
            if (q_count == 0) r.code = rrps_pkg::RES_NONE;
            else r.sw = 1'b1;
          end else begin
            for (int unsigned k = found; k + 1 < q_count; k++) begin
              q_id[slot_at(k)] = q_id[slot_at(k + 1)];
              q_addr[slot_at(k)] = q_addr[slot_at(k + 1)];
            end
            q_count--;
          end
        end
      end
    endcase
    if (q_count != 0) begin
      r.pid = q_id[q_head];
      r.base = q_addr[q_head];
    end
    r.count = rrps_pkg::QCNT_W'(q_count);
    return r;
  endfunction

  function automatic logic [rrps_pkg::ID_W-1:0] fresh_pid();
    // A small pool of ids makes duplicates and hits on remove common.
    if ($urandom_range(3) != 0) return rrps_pkg::ID_W'($urandom_range(15));
    return rrps_pkg::ID_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offers one word, records its expectation on acceptance, then paces the sender.
  task automatic offer_word(input logic [rrps_pkg::OP_W-1:0] op,
                            input logic [rrps_pkg::ID_W-1:0] pid,
                            input logic [rrps_pkg::ADDR_W-1:0] base, input logic typed,
                            input sched_result_t want);
    sched_result_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.pid <= pid;
    in_ch.base <= base;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = schedule_step(op, pid, base);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      gap_cycles = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_cycles != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_cycles) @(negedge clk);
      end
    end
  endtask

  // Holds the sender until every expected result has come back.
  task automatic settle_queue();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_quantum(input logic [rrps_pkg::TICK_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    q_quantum = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: a random stall pattern, redrawn at regular points of its step counter, plus long hold-offs on request.
  always @(negedge clk) begin
    if (holdoff_given != holdoff_asked) begin
      holdoff_given = holdoff_asked;
      holdoff_left = HOLDOFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (pattern_step % 64 == 0) begin
        stall_pattern = ($urandom_range(3) == 0) ? 8'hFF : (8'($urandom) | 8'h11);
      end
      out_ch.ready <= stall_pattern[pattern_step % 8];
      pattern_step++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_word = '{out_ch.result_code, out_ch.switched, out_ch.current_pid,
                    out_ch.current_base, out_ch.queue_count};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  results_seen));
      end else begin
        wanted_word = pending_results.pop_front();
        if (seen_word.code !== wanted_word.code)
          report_mismatch($sformatf("word %0d result_code %0d, expected %0d",
                                    results_seen, seen_word.code, wanted_word.code));
        if (seen_word.sw !== wanted_word.sw)
          report_mismatch($sformatf("word %0d switched %0b, expected %0b",
                                    results_seen, seen_word.sw, wanted_word.sw));
        if (seen_word.pid !== wanted_word.pid)
          report_mismatch($sformatf("word %0d current_pid %h, expected %h",
                                    results_seen, seen_word.pid, wanted_word.pid));
        if (seen_word.base !== wanted_word.base)
          report_mismatch($sformatf("word %0d current_base %h, expected %h",
                                    results_seen, seen_word.base, wanted_word.base));
        if (seen_word.count !== wanted_word.count)
          report_mismatch($sformatf("word %0d queue_count %0d, expected %0d",
                                    results_seen, seen_word.count, wanted_word.count));
      end
      results_seen++;
    end
  end

  initial begin
    #40_000_000;
    $display("round_robin_process_scheduler_unit regression: fail");
    $finish;
  end

  initial begin
    step_row_t directed_rows [21];
    logic [rrps_pkg::TICK_W-1:0] phase_quanta [RANDOM_PHASES];
    int add_pct;
    int roll;
    logic [rrps_pkg::OP_W-1:0] op;
    logic [rrps_pkg::ID_W-1:0] pid;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = rrps_pkg::OP_TICK;
    in_ch.pid = '0;
    in_ch.base = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    q_head = 0;
    q_count = 0;
    q_ticks = '0;
    q_quantum = rrps_pkg::QUANTUM_RESET;

    directed_rows = '{
      '{ROW_WORD, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0, 32'd1, 1'b1, EMPTY_NONE},
      '{ROW_WORD, rrps_pkg::OP_TERMINATE, 16'h0000, 16'h0000, 16'h0, 32'd1, 1'b1, EMPTY_NONE},
      '{ROW_WORD, rrps_pkg::OP_REMOVE, 16'h1234, 16'h0000, 16'h0, 32'd1, 1'b1, EMPTY_NONE},
      '{ROW_WORD, rrps_pkg::OP_ADD, 16'hFFFF, 16'h0000, 16'h0, 32'd1, 1'b1,
        '{rrps_pkg::RES_OK, 1'b1, 16'hFFFF, 16'h0000, 5'd1}},
      // A lone entry with a different id stays put.
      '{ROW_WORD, rrps_pkg::OP_REMOVE, 16'h1234, 16'hFFFF, 16'h0, 32'd1, 1'b1,
        '{rrps_pkg::RES_NOT_FOUND, 1'b0, 16'hFFFF, 16'h0000, 5'd1}},
      '{ROW_QUANTUM, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0, '0},
      // Expiry with a single entry restarts the slice without a switch.
      '{ROW_WORD, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0, 32'd1, 1'b1,
        '{rrps_pkg::RES_OK, 1'b0, 16'hFFFF, 16'h0000, 5'd1}},
      '{ROW_WORD, rrps_pkg::OP_ADD, 16'h0000, 16'hFFFF, 16'h0, 32'd1, 1'b1,
        '{rrps_pkg::RES_OK, 1'b0, 16'hFFFF, 16'h0000, 5'd2}},
      '{ROW_WORD, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0, 32'd1, 1'b1,
        '{rrps_pkg::RES_OK, 1'b1, 16'h0000, 16'hFFFF, 5'd2}},
      '{ROW_WORD, rrps_pkg::OP_ADD, 16'hFFFF, 16'h5555, 16'h0, 32'd1, 1'b0, '0},
      // Duplicate id: the earlier of the two, not the head, is removed.
      '{ROW_WORD, rrps_pkg::OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0, 32'd1, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_ADD, 16'h0100, 16'h8000, 16'h0, 32'd14, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_ADD, 16'hBEEF, 16'hBEEF, 16'h0, 32'd1, 1'b1,
        '{rrps_pkg::RES_FULL, 1'b0, 16'h0000, 16'hFFFF, 5'd16}},
      '{ROW_WORD, rrps_pkg::OP_REMOVE, 16'h0105, 16'h0000, 16'h0, 32'd1, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h0, 32'd1, 1'b0, '0},
      '{ROW_QUANTUM, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'hFFFF, 32'd0, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0, 32'd3, 1'b0, '0},
      // The quantum drops below the slice count, so the counter keeps running past it.
      '{ROW_QUANTUM, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0001, 32'd0, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0, 32'd6, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_TERMINATE, 16'h0000, 16'h0000, 16'h0, 32'd13, 1'b0, '0},
      '{ROW_WORD, rrps_pkg::OP_TERMINATE, 16'h0000, 16'h0000, 16'h0, 32'd1, 1'b1, EMPTY_NONE}
    };

    phase_quanta = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd10, 16'd0, 16'd3};
    phase_quanta[4] = rrps_pkg::TICK_W'($urandom_range(4, 20));
    phase_quanta[6] = rrps_pkg::TICK_W'($urandom);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_QUANTUM) begin
        settle_queue();
        write_quantum(directed_rows[i].quantum);
      end else begin
        for (int rep = 0; rep < int'(directed_rows[i].reps); rep++) begin
          offer_word(directed_rows[i].op, directed_rows[i].pid + rrps_pkg::ID_W'(rep),
                     directed_rows[i].base + rrps_pkg::ADDR_W'(rep), directed_rows[i].typed,
                     directed_rows[i].want);
        end
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_queue();
      write_quantum(phase_quanta[phase]);
      add_pct = $urandom_range(30, 60);
      // One phase starts with a long receiver hold-off so that the input backs up.
      if (phase == 2) holdoff_asked++;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        pid = fresh_pid();
        if (roll < add_pct) begin
          op = rrps_pkg::OP_ADD;
        end else if (roll < add_pct + 15) begin
          op = rrps_pkg::OP_REMOVE;
          if (q_count != 0 && $urandom_range(4) != 0)
            pid = q_id[slot_at($urandom_range(q_count - 1))];
        end else if (roll < add_pct + 25) begin
          op = rrps_pkg::OP_TERMINATE;
        end else begin
          op = rrps_pkg::OP_TICK;
        end
        offer_word(op, pid, rrps_pkg::ADDR_W'($urandom), 1'b0, '0);
      end
    end

    settle_queue();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("round_robin_process_scheduler_unit regression: pass");
    end else begin
      $display("round_robin_process_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rrps_pkg.sv
hw/rtl/rrps_in_if.sv
hw/rtl/rrps_out_if.sv
hw/rtl/rrps_cfg_if.sv
hw/rtl/rrps_cell.sv
hw/rtl/round_robin_process_scheduler_unit.sv
sim/tb_round_robin_process_scheduler_unit.sv
